@@ design/set_assoc_cache_tag_lru_unit_defines.svh @@
// assertion macros for the tag/lru unit back end
// no dependencies; included by sacl_back, which checks its own logic
`ifndef SET_ASSOC_CACHE_TAG_LRU_UNIT_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_LRU_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SACL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SACL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sacl_pkg.sv @@
// shared types, widths and codes for the set-associative tag/lru unit
// no dependencies; used by every other file of the block but the assertion macro header
package sacl_pkg;

    localparam int SET_IDX_W   = 4;
    localparam int TAG_IN_W    = 20;
    localparam int PAGE_W      = 20;
    localparam int STAMP_W     = 31;
    localparam int WAY_OUT_W   = 2;
    localparam int COUNT_W     = 32;
    localparam int BLK_LOG2_W  = 4;
    localparam int PAGE_LOG2_W = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam int DEF_NUM_SETS = 16;
    localparam int DEF_NUM_WAYS = 4;
    localparam int DEF_TAG_BITS = 20;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [BLK_LOG2_W-1:0]  BLK_LOG2_RST  = 4'd4;
    localparam logic [PAGE_LOG2_W-1:0] PAGE_LOG2_RST = 5'd12;

    localparam logic [CFG_IDX_W-1:0] CFG_REG_BLOCK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_PAGE  = 2'd1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_FILL   = 2'd1,
        OP_INVAL  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [SET_IDX_W-1:0] set_idx;
        logic [TAG_IN_W-1:0]  tag;
        logic [PAGE_W-1:0]    page;
        logic [STAMP_W-1:0]   stamp;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_DONE
    } back_state_t;

endpackage

@@ design/sacl_ifs.sv @@
// valid/ready channel interfaces: request, response and register write
// depends on sacl_pkg for field widths
interface sacl_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      opcode;
    logic [sacl_pkg::SET_IDX_W-1:0]  set_index;
    logic [sacl_pkg::TAG_IN_W-1:0]   tag_value;
    logic [sacl_pkg::PAGE_W-1:0]     target_page;
    logic [sacl_pkg::STAMP_W-1:0]    now_cycle;

    modport source (output valid, opcode, set_index, tag_value, target_page, now_cycle,
                    input ready);
    modport sink (input valid, opcode, set_index, tag_value, target_page, now_cycle,
                  output ready);
endinterface

interface sacl_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [sacl_pkg::WAY_OUT_W-1:0]  way;
    logic [sacl_pkg::COUNT_W-1:0]    hit_total;
    logic [sacl_pkg::COUNT_W-1:0]    miss_total;

    modport source (output valid, hit, way, hit_total, miss_total, input ready);
    modport sink (input valid, hit, way, hit_total, miss_total, output ready);
endinterface

interface sacl_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sacl_pkg::CFG_IDX_W-1:0]   index;
    logic [sacl_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/sacl_front.sv @@
// front end: takes request transactions, decodes the opcode and folds the set index
// depends on sacl_pkg and sacl_req_if
module sacl_front #(
    parameter int NUM_SETS = sacl_pkg::DEF_NUM_SETS
) (
    sacl_req_if.sink             req,
    input  sacl_pkg::q_status_t  q_status,
    output logic                 push,
    output sacl_pkg::item_t      push_item
);

    logic [sacl_pkg::SET_IDX_W-1:0] set_wrap;

    // set index wraps modulo the set count; per-code constant table
    always_comb
    begin
        set_wrap = '0;
        for (int i = 0; i < (1 << sacl_pkg::SET_IDX_W); i++)
        begin
            if (req.set_index == sacl_pkg::SET_IDX_W'(i))
            begin
                set_wrap = sacl_pkg::SET_IDX_W'(i % NUM_SETS);
            end
        end
    end

    assign req.ready = !q_status.full;
    assign push      = req.valid && !q_status.full;

    always_comb
    begin
        push_item.op      = sacl_pkg::op_t'(req.opcode);
        push_item.set_idx = set_wrap;
        push_item.tag     = req.tag_value;
        push_item.page    = req.target_page;
        push_item.stamp   = req.now_cycle;
    end

endmodule

@@ design/sacl_queue.sv @@
// two-entry queue of decoded requests between front and back
// depends on sacl_pkg
module sacl_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sacl_pkg::item_t      push_item,
    input  logic                 pop,
    output sacl_pkg::item_t      pop_item,
    output sacl_pkg::q_status_t  status
);

    sacl_pkg::item_t                slot_reg [sacl_pkg::QUEUE_DEPTH];
    logic [sacl_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [sacl_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [sacl_pkg::QPTR_W:0]      count_reg, count_next;

    always_comb
    begin
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item     = slot_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (sacl_pkg::QPTR_W+1)'(sacl_pkg::QUEUE_DEPTH));

endmodule

@@ design/sacl_back.sv @@
// back end: tag/valid/stamp memory, lookup, fill, page scan, counters, result register
// depends on sacl_pkg, sacl_rsp_if and the assertion macro header
`include "set_assoc_cache_tag_lru_unit_defines.svh"

module sacl_back #(
    parameter int NUM_SETS = sacl_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS = sacl_pkg::DEF_NUM_WAYS,
    parameter int TAG_BITS = sacl_pkg::DEF_TAG_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sacl_pkg::q_status_t                 q_status,
    input  sacl_pkg::item_t                     item,
    output logic                                pop,
    input  logic [sacl_pkg::BLK_LOG2_W-1:0]     blk_log2,
    input  logic [sacl_pkg::PAGE_LOG2_W-1:0]    pg_log2,
    sacl_rsp_if.source                          rsp
);

    localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int LEAVES  = 1 << WAY_W;
    localparam int AW      = TAG_BITS + SET_W;
    localparam int MAX_SHL = (1 << sacl_pkg::BLK_LOG2_W) - 1;
    localparam int SW      = (AW + MAX_SHL > sacl_pkg::PAGE_W) ? AW + MAX_SHL : sacl_pkg::PAGE_W;
    localparam int STAMP_W = sacl_pkg::STAMP_W;

    // set-wide rows: one read and one write per cycle
    logic [NUM_WAYS-1:0]                valid_mem [NUM_SETS];
    logic [NUM_WAYS-1:0][TAG_BITS-1:0]  tag_mem   [NUM_SETS];
    logic [NUM_WAYS-1:0][STAMP_W-1:0]   stamp_mem [NUM_SETS];

    logic [NUM_WAYS-1:0]                rd_valid_reg;
    logic [NUM_WAYS-1:0][TAG_BITS-1:0]  rd_tag_reg;
    logic [NUM_WAYS-1:0][STAMP_W-1:0]   rd_stamp_reg;

    logic                               rd_en;
    logic [SET_W-1:0]                   rd_addr;
    logic                               wr_en;
    logic [SET_W-1:0]                   wr_addr;
    logic [NUM_WAYS-1:0]                wr_valid;
    logic [NUM_WAYS-1:0][TAG_BITS-1:0]  wr_tag;
    logic [NUM_WAYS-1:0][STAMP_W-1:0]   wr_stamp;

    sacl_pkg::back_state_t              state_reg, state_next;
    sacl_pkg::item_t                    cur_reg, cur_next;
    logic [SET_W-1:0]                   scan_reg, scan_next;
    logic                               pend_reg, pend_next;
    logic [SET_W-1:0]                   pend_set_reg, pend_set_next;
    logic [sacl_pkg::COUNT_W-1:0]       hits_reg, hits_next;
    logic [sacl_pkg::COUNT_W-1:0]       misses_reg, misses_next;

    logic                               rsp_valid_reg, rsp_valid_next;
    logic                               rsp_hit_reg, rsp_hit_next;
    logic [sacl_pkg::WAY_OUT_W-1:0]     rsp_way_reg, rsp_way_next;
    logic [sacl_pkg::COUNT_W-1:0]       rsp_hits_reg, rsp_hits_next;
    logic [sacl_pkg::COUNT_W-1:0]       rsp_misses_reg, rsp_misses_next;

    logic [TAG_BITS-1:0]                tag_cur;
    logic [SET_W-1:0]                   cur_set;
    logic [NUM_WAYS-1:0]                hit_vec;
    logic                               hit_any;
    logic [WAY_W-1:0]                   hit_way;
    logic                               has_free;
    logic [WAY_W-1:0]                   free_way;
    logic [WAY_W-1:0]                   victim;
    logic [NUM_WAYS-1:0]                inv_hit;
    logic                               slot_free;

    logic [STAMP_W-1:0]                 node_stamp [2*LEAVES];
    logic [WAY_W-1:0]                   node_way   [2*LEAVES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            valid_mem[wr_addr] <= wr_valid;
            tag_mem[wr_addr]   <= wr_tag;
            stamp_mem[wr_addr] <= wr_stamp;
        end
        if (rd_en)
        begin
            rd_valid_reg <= valid_mem[rd_addr];
            rd_tag_reg   <= tag_mem[rd_addr];
            rd_stamp_reg <= stamp_mem[rd_addr];
        end
    end

    assign tag_cur   = TAG_BITS'(cur_reg.tag);
    assign cur_set   = SET_W'(cur_reg.set_idx);
    assign slot_free = !rsp_valid_reg || rsp.ready;

    // tag compare and first invalid way
    always_comb
    begin
        hit_vec  = '0;
        hit_way  = '0;
        free_way = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            hit_vec[w] = rd_valid_reg[w] && (rd_tag_reg[w] == tag_cur);
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (!rd_valid_reg[w])
            begin
                free_way = WAY_W'(w);
            end
        end
        hit_any  = |hit_vec;
        has_free = !(&rd_valid_reg);
    end

    // victim: first invalid way if any, else oldest stamp, ties to the lower way; all stamps at max gives way 0
    always_comb
    begin
        node_stamp[0] = '0;
        node_way[0]   = '0;
        for (int n = 0; n < LEAVES; n++)
        begin
            if (n < NUM_WAYS)
            begin
                node_stamp[LEAVES+n] = rd_stamp_reg[WAY_W'(n)];
            end
            else
            begin
                node_stamp[LEAVES+n] = '1;
            end
            node_way[LEAVES+n] = WAY_W'(n);
        end
        for (int n = LEAVES - 1; n >= 1; n--)
        begin
            if (node_stamp[2*n+1] < node_stamp[2*n])
            begin
                node_stamp[n] = node_stamp[2*n+1];
                node_way[n]   = node_way[2*n+1];
            end
            else
            begin
                node_stamp[n] = node_stamp[2*n];
                node_way[n]   = node_way[2*n];
            end
        end
        victim = has_free ? free_way : node_way[1];
    end

    // page number of each way of the row read during the scan
    always_comb
    begin
        logic [AW-1:0] line_addr;
        logic [SW-1:0] shifted;
        line_addr = '0;
        shifted   = '0;
        inv_hit   = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            line_addr  = AW'(rd_tag_reg[w]) * AW'(NUM_SETS) + AW'(pend_set_reg);
            shifted    = (SW'(line_addr) << blk_log2) >> pg_log2;
            inv_hit[w] = rd_valid_reg[w] && (shifted == SW'(cur_reg.page));
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        pend_set_next   = pend_set_reg;
        hits_next       = hits_reg;
        misses_next     = misses_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_hit_next    = rsp_hit_reg;
        rsp_way_next    = rsp_way_reg;
        rsp_hits_next   = rsp_hits_reg;
        rsp_misses_next = rsp_misses_reg;
        pop             = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = SET_W'(item.set_idx);
        wr_en           = 1'b0;
        wr_addr         = cur_set;
        wr_valid        = rd_valid_reg;
        wr_tag          = rd_tag_reg;
        wr_stamp        = rd_stamp_reg;

        case (state_reg)
            sacl_pkg::ST_CLEAR:
            begin
                wr_en     = 1'b1;
                wr_addr   = scan_reg;
                wr_valid  = '0;
                scan_next = scan_reg + 1'b1;
                if (scan_reg == SET_W'(NUM_SETS - 1))
                begin
                    scan_next  = '0;
                    state_next = sacl_pkg::ST_IDLE;
                end
            end
            sacl_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop      = 1'b1;
                    cur_next = item;
                    case (item.op)
                        sacl_pkg::OP_LOOKUP,
                        sacl_pkg::OP_FILL:
                        begin
                            rd_en      = 1'b1;
                            state_next = sacl_pkg::ST_ACCESS;
                        end
                        sacl_pkg::OP_INVAL:
                        begin
                            scan_next  = '0;
                            pend_next  = 1'b0;
                            state_next = sacl_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            state_next = sacl_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            sacl_pkg::ST_ACCESS:
            begin
                if (slot_free)
                begin
                    wr_en          = 1'b1;
                    rsp_valid_next = 1'b1;
                    rsp_hit_next   = 1'b0;
                    if (cur_reg.op == sacl_pkg::OP_FILL)
                    begin
                        wr_valid[victim] = 1'b1;
                        wr_tag[victim]   = tag_cur;
                        wr_stamp[victim] = cur_reg.stamp;
                        rsp_way_next     = sacl_pkg::WAY_OUT_W'(victim);
                    end
                    else if (hit_any)
                    begin
                        wr_stamp[hit_way] = cur_reg.stamp;
                        if (hits_reg != sacl_pkg::COUNT_MAX)
                        begin
                            hits_next = hits_reg + 1'b1;
                        end
                        rsp_hit_next = 1'b1;
                        rsp_way_next = sacl_pkg::WAY_OUT_W'(hit_way);
                    end
                    else
                    begin
                        if (misses_reg != sacl_pkg::COUNT_MAX)
                        begin
                            misses_next = misses_reg + 1'b1;
                        end
                        rsp_way_next = '0;
                    end
                    rsp_hits_next   = hits_next;
                    rsp_misses_next = misses_next;
                    state_next      = sacl_pkg::ST_IDLE;
                end
            end
            sacl_pkg::ST_SCAN:
            begin
                // read row scan while writing back the row read in the previous cycle
                rd_en         = 1'b1;
                rd_addr       = scan_reg;
                pend_next     = 1'b1;
                pend_set_next = scan_reg;
                if (pend_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = pend_set_reg;
                    wr_valid = rd_valid_reg & ~inv_hit;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == SET_W'(NUM_SETS - 1))
                begin
                    scan_next  = '0;
                    state_next = sacl_pkg::ST_SCAN_LAST;
                end
            end
            sacl_pkg::ST_SCAN_LAST:
            begin
                wr_en      = 1'b1;
                wr_addr    = pend_set_reg;
                wr_valid   = rd_valid_reg & ~inv_hit;
                pend_next  = 1'b0;
                state_next = sacl_pkg::ST_DONE;
            end
            sacl_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_hit_next    = 1'b0;
                    rsp_way_next    = '0;
                    rsp_hits_next   = hits_reg;
                    rsp_misses_next = misses_reg;
                    state_next      = sacl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sacl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sacl_pkg::ST_CLEAR;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        pend_set_reg   <= pend_set_next;
        rsp_hit_reg    <= rsp_hit_next;
        rsp_way_reg    <= rsp_way_next;
        rsp_hits_reg   <= rsp_hits_next;
        rsp_misses_reg <= rsp_misses_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.hit        = rsp_hit_reg;
    assign rsp.way        = rsp_way_reg;
    assign rsp.hit_total  = rsp_hits_reg;
    assign rsp.miss_total = rsp_misses_reg;

    `SACL_ASSERT_NOW(a_wr_addr_range, clk, rst_n, wr_en, wr_addr <= SET_W'(NUM_SETS - 1), "row write outside the set range")
    `SACL_ASSERT_NEXT(a_hit_count, clk, rst_n, state_reg == sacl_pkg::ST_ACCESS && slot_free && cur_reg.op == sacl_pkg::OP_LOOKUP && hit_any, hits_reg == $past(hits_reg) + 1 || $past(hits_reg) == sacl_pkg::COUNT_MAX, "lookup hit not counted")
    `SACL_ASSERT_NOW(a_fill_installs, clk, rst_n, state_reg == sacl_pkg::ST_ACCESS && slot_free && cur_reg.op == sacl_pkg::OP_FILL, wr_en && wr_valid[victim], "fill does not set the victim valid")
    `SACL_ASSERT_NOW(a_clear_quiet, clk, rst_n, state_reg == sacl_pkg::ST_CLEAR, !rsp_valid_reg && !pop, "activity during the clearing pass")

endmodule

@@ design/set_assoc_cache_tag_lru_unit.sv @@
// Tag array of a set-associative cache with timestamp lru replacement.
// Channels: req (sink) carries opcode, set_index, tag_value, target_page and
// now_cycle; rsp (source) returns hit, way, hit_total and miss_total, one
// transaction per request; cfg (sink) writes block_bytes_log2 (index 0) and
// page_bytes_log2 (index 1), always ready, to be used while the unit is idle.
// Lookup and fill in the back end first read the set-wide row from the tag/stamp
// memory, then compare, pick a victim and write back.
// The response is registered once the request has passed the queue and the row read;
// the back end takes no new lookup or fill until it has answered the current one.
// Page invalidate walks the memory one set a cycle, writing back each row after it
// is read; its response is registered after the last row is written back.
// A two-entry request queue lets req be taken while a response waits on rsp.
// After reset a clearing pass over all NUM_SETS sets zeroes the valid bits; requests
// are queued but not served until it ends. Counters reset to zero.
// When rsp is stalled the response register holds and the back end waits; the
// queue then fills and req.ready drops.
// Depends on sacl_pkg, sacl_ifs, sacl_front, sacl_queue and sacl_back.
module set_assoc_cache_tag_lru_unit #(
    parameter int NUM_SETS = sacl_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS = sacl_pkg::DEF_NUM_WAYS,
    parameter int TAG_BITS = sacl_pkg::DEF_TAG_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    sacl_cfg_if.sink    cfg,
    sacl_req_if.sink    req,
    sacl_rsp_if.source  rsp
);

    logic [sacl_pkg::BLK_LOG2_W-1:0]  blk_log2_reg;
    logic [sacl_pkg::PAGE_LOG2_W-1:0] pg_log2_reg;

    sacl_pkg::q_status_t  q_status;
    sacl_pkg::item_t      push_item;
    sacl_pkg::item_t      pop_item;
    logic                 push;
    logic                 pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_log2_reg <= sacl_pkg::BLK_LOG2_RST;
            pg_log2_reg  <= sacl_pkg::PAGE_LOG2_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sacl_pkg::CFG_REG_BLOCK: blk_log2_reg <= cfg.data[sacl_pkg::BLK_LOG2_W-1:0];
                sacl_pkg::CFG_REG_PAGE:  pg_log2_reg  <= cfg.data[sacl_pkg::PAGE_LOG2_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    sacl_front #(
        .NUM_SETS (NUM_SETS)
    ) u_front (
        .req       (req),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    sacl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    sacl_back #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS),
        .TAG_BITS (TAG_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .item     (pop_item),
        .pop      (pop),
        .blk_log2 (blk_log2_reg),
        .pg_log2  (pg_log2_reg),
        .rsp      (rsp)
    );

endmodule

@@ sim/sacl_tb_pkg.sv @@
// testbench types: expected response transaction and the lru stamp sentinel
// depends on sacl_pkg for field widths
`timescale 1ns / 100ps
package sacl_tb_pkg;

    localparam logic [sacl_pkg::STAMP_W-1:0] STAMP_NONE = 31'h7fffffff;

    typedef struct packed {
        logic                           hit;
        logic [sacl_pkg::WAY_OUT_W-1:0] way;
        logic [sacl_pkg::COUNT_W-1:0]   hits;
        logic [sacl_pkg::COUNT_W-1:0]   misses;
    } answer_t;

endpackage

@@ sim/set_assoc_cache_tag_lru_unit_tb.sv @@
// self-checking testbench for the set-associative tag/lru unit
// predicts hit, way and counters per request; depends on sacl_pkg, sacl_tb_pkg and sacl_ifs
`timescale 1ns / 100ps
module set_assoc_cache_tag_lru_unit_tb;

    localparam int SETS = sacl_pkg::DEF_NUM_SETS;
    localparam int WAYS = sacl_pkg::DEF_NUM_WAYS;
    localparam int LINE_CNT = SETS * WAYS;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;

    sacl_cfg_if cfg ();
    sacl_req_if req ();
    sacl_rsp_if rsp ();

    set_assoc_cache_tag_lru_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    // predictor state
    logic                                 mdl_valid [LINE_CNT];
    logic [sacl_pkg::TAG_IN_W-1:0]        mdl_tag [LINE_CNT];
    logic [sacl_pkg::STAMP_W-1:0]         mdl_stamp [LINE_CNT];
    logic [sacl_pkg::COUNT_W-1:0]         mdl_hits;
    logic [sacl_pkg::COUNT_W-1:0]         mdl_misses;
    logic [sacl_pkg::BLK_LOG2_W-1:0]      mdl_blk_log2;
    logic [sacl_pkg::PAGE_LOG2_W-1:0]     mdl_page_log2;

    sacl_pkg::item_t       pending_items [$];
    sacl_tb_pkg::answer_t  expected_answers [$];
    int      errors;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_off_cycles;
    int      quiet_cycles;

    function automatic sacl_tb_pkg::answer_t predict_access(sacl_pkg::item_t it);
        sacl_tb_pkg::answer_t a;
        int base;
        int best;
        logic [sacl_pkg::STAMP_W-1:0] oldest;
        logic [63:0] addr;
        logic [63:0] ppn;
        bit found;
        a = '0;
        base = int'(it.set_idx) * WAYS;
        case (it.op)
            sacl_pkg::OP_LOOKUP:
            begin
                found = 0;
                for (int w = 0; w < WAYS; w++)
                begin
                    if (!found && mdl_valid[base+w] && mdl_tag[base+w] == it.tag)
                    begin
                        found = 1;
                        a.way = sacl_pkg::WAY_OUT_W'(w);
                    end
                end
                a.hit = found;
                if (found)
                begin
                    mdl_stamp[base+int'(a.way)] = it.stamp;
                    if (mdl_hits != sacl_pkg::COUNT_MAX)
                        mdl_hits++;
                end
                else if (mdl_misses != sacl_pkg::COUNT_MAX)
                    mdl_misses++;
            end
            sacl_pkg::OP_FILL:
            begin
                best = -1;
                for (int w = WAYS - 1; w >= 0; w--)
                    if (!mdl_valid[base+w])
                        best = w;
                if (best < 0)
                begin
                    best = 0;
                    oldest = sacl_tb_pkg::STAMP_NONE;
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (mdl_stamp[base+w] < oldest)
                        begin
                            oldest = mdl_stamp[base+w];
                            best = w;
                        end
                    end
                end
                a.way = sacl_pkg::WAY_OUT_W'(best);
                mdl_valid[base+best] = 1;
                mdl_tag[base+best] = it.tag;
                mdl_stamp[base+best] = it.stamp;
            end
            sacl_pkg::OP_INVAL:
            begin
                for (int i = 0; i < LINE_CNT; i++)
                begin
                    if (mdl_valid[i])
                    begin
                        addr = 64'(mdl_tag[i]) * 64'(SETS) + 64'(i / WAYS);
                        ppn = (addr << mdl_blk_log2) >> mdl_page_log2;
                        if (ppn == 64'(it.page))
                            mdl_valid[i] = 0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        a.hits = mdl_hits;
        a.misses = mdl_misses;
        return a;
    endfunction

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 0;
            req.opcode <= sacl_pkg::OP_NOP;
            req.set_index <= '0;
            req.tag_value <= '0;
            req.target_page <= '0;
            req.now_cycle <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_answers.push_back(predict_access(sacl_pkg::item_t'({req.opcode,
                    req.set_index, req.tag_value, req.target_page, req.now_cycle})));
            if ((!req.valid || req.ready) && pending_items.size() > 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                sacl_pkg::item_t it;
                it = pending_items.pop_front();
                req.valid <= 1;
                req.opcode <= it.op;
                req.set_index <= it.set_idx;
                req.tag_value <= it.tag;
                req.target_page <= it.page;
                req.now_cycle <= it.stamp;
            end
            else if (req.ready)
                req.valid <= 0;
        end
    end

    // receiver ready, with long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp.ready <= 0;
        end
        else
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || pending_items.size() == 0
                && expected_answers.size() == 0)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $error("response transaction with nothing expected");
                    errors++;
                end
                else
                begin
                    sacl_tb_pkg::answer_t e;
                    e = expected_answers.pop_front();
                    if (rsp.hit !== e.hit)
                    begin
                        $error("hit: expected %0h actual %0h", e.hit, rsp.hit);
                        errors++;
                    end
                    if (rsp.way !== e.way)
                    begin
                        $error("way: expected %0h actual %0h", e.way, rsp.way);
                        errors++;
                    end
                    if (rsp.hit_total !== e.hits)
                    begin
                        $error("hit_total: expected %0h actual %0h", e.hits, rsp.hit_total);
                        errors++;
                    end
                    if (rsp.miss_total !== e.misses)
                    begin
                        $error("miss_total: expected %0h actual %0h", e.misses,
                               rsp.miss_total);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic sacl_pkg::item_t make_item(sacl_pkg::op_t op, int set_idx,
                                                  logic [sacl_pkg::TAG_IN_W-1:0] tag,
                                                  logic [sacl_pkg::PAGE_W-1:0] page,
                                                  logic [sacl_pkg::STAMP_W-1:0] stamp);
        sacl_pkg::item_t it;
        it.op = op;
        it.set_idx = sacl_pkg::SET_IDX_W'(set_idx);
        it.tag = tag;
        it.page = page;
        it.stamp = stamp;
        return it;
    endfunction

    function automatic logic [sacl_pkg::STAMP_W-1:0] rand_stamp();
        case ($urandom_range(3))
            0: return sacl_tb_pkg::STAMP_NONE;
            1: return sacl_pkg::STAMP_W'($urandom_range(7));
            default: return sacl_pkg::STAMP_W'($urandom);
        endcase
    endfunction

    // random traffic over a small tag pool so lookups hit and invalidates land
    task automatic queue_random(int count);
        logic [sacl_pkg::TAG_IN_W-1:0] tag;
        logic [63:0] addr;
        int s;
        int r;
        for (int n = 0; n < count; n++)
        begin
            s = $urandom_range(SETS - 1);
            r = $urandom_range(99);
            tag = (r < 10) ? sacl_pkg::TAG_IN_W'($urandom)
                  : sacl_pkg::TAG_IN_W'($urandom_range(7)
                  | ($urandom_range(1) ? 20'hffff8 : 20'h0));
            addr = (64'(tag) * 64'(SETS) + 64'(s)) << mdl_blk_log2;
            if (r < 45)
                pending_items.push_back(make_item(sacl_pkg::OP_LOOKUP, s, tag,
                    sacl_pkg::PAGE_W'($urandom), rand_stamp()));
            else if (r < 85)
                pending_items.push_back(make_item(sacl_pkg::OP_FILL, s, tag,
                    sacl_pkg::PAGE_W'($urandom), rand_stamp()));
            else if (r < 95)
                pending_items.push_back(make_item(sacl_pkg::OP_INVAL, s, tag,
                    sacl_pkg::PAGE_W'(addr >> mdl_page_log2), sacl_pkg::STAMP_W'($urandom)));
            else
                pending_items.push_back(make_item(($urandom_range(1) ? sacl_pkg::OP_NOP
                    : sacl_pkg::OP_INVAL), s, tag, sacl_pkg::PAGE_W'($urandom),
                    sacl_pkg::STAMP_W'($urandom)));
        end
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || expected_answers.size() > 0)
            @(posedge clk);
        repeat (SETS + 8) @(posedge clk);
    endtask

    task automatic write_reg(logic [sacl_pkg::CFG_IDX_W-1:0] idx,
                             logic [sacl_pkg::CFG_DATA_W-1:0] value);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 0;
        if (idx == sacl_pkg::CFG_REG_BLOCK)
            mdl_blk_log2 = value[sacl_pkg::BLK_LOG2_W-1:0];
        else if (idx == sacl_pkg::CFG_REG_PAGE)
            mdl_page_log2 = value[sacl_pkg::PAGE_LOG2_W-1:0];
    endtask

    initial
    begin
        errors = 0;
        quiet_cycles = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cfg.valid = 0;
        cfg.index = '0;
        cfg.data = '0;
        for (int i = 0; i < LINE_CNT; i++)
        begin
            mdl_valid[i] = 0;
            mdl_tag[i] = '0;
            mdl_stamp[i] = '0;
        end
        mdl_hits = '0;
        mdl_misses = '0;
        mdl_blk_log2 = sacl_pkg::BLK_LOG2_RST;
        mdl_page_log2 = sacl_pkg::PAGE_LOG2_RST;
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: miss on empty, fills into all ways, lru eviction, ties, extremes
        pending_items.push_back(make_item(sacl_pkg::OP_LOOKUP, 0, '0, '0, '0));
        for (int w = 0; w < WAYS; w++)
            pending_items.push_back(make_item(sacl_pkg::OP_FILL, 15,
                sacl_pkg::TAG_IN_W'(20'hfffff - w), '0, sacl_tb_pkg::STAMP_NONE));
        pending_items.push_back(make_item(sacl_pkg::OP_FILL, 15, 20'h12345, '0, 31'd9));
        pending_items.push_back(make_item(sacl_pkg::OP_LOOKUP, 15, 20'h12345, '0, 31'd3));
        pending_items.push_back(make_item(sacl_pkg::OP_LOOKUP, 15, 20'hffffe, '0, 31'd3));
        pending_items.push_back(make_item(sacl_pkg::OP_FILL, 15, 20'h00001, '0, '0));
        pending_items.push_back(make_item(sacl_pkg::OP_FILL, 15, 20'h00002, '0, 31'd1));
        pending_items.push_back(make_item(sacl_pkg::OP_LOOKUP, 15, 20'h00002, '0,
            sacl_tb_pkg::STAMP_NONE));
        pending_items.push_back(make_item(sacl_pkg::OP_NOP, 15, 20'hfffff, 20'hfffff,
            sacl_tb_pkg::STAMP_NONE));
        pending_items.push_back(make_item(sacl_pkg::OP_INVAL, 0, '0, 20'hfffff, '0));
        pending_items.push_back(make_item(sacl_pkg::OP_INVAL, 0, '0, 20'h0ffff, '0));
        pending_items.push_back(make_item(sacl_pkg::OP_LOOKUP, 15, 20'h00002, '0, '0));
        pending_items.push_back(make_item(sacl_pkg::OP_FILL, 3, 20'h0, '0, '0));
        pending_items.push_back(make_item(sacl_pkg::OP_INVAL, 0, '0, 20'h0, '0));
        pending_items.push_back(make_item(sacl_pkg::OP_LOOKUP, 3, 20'h0, '0, '0));
        drain();

        // register extremes, with idling phases
        write_reg(sacl_pkg::CFG_REG_BLOCK, 8'd0);
        write_reg(sacl_pkg::CFG_REG_PAGE, 8'd16);
        queue_random(400);
        drain();
        write_reg(sacl_pkg::CFG_REG_BLOCK, 8'd12);
        write_reg(sacl_pkg::CFG_REG_PAGE, 8'd0);
        send_idle_pct = 88;
        queue_random(350);
        drain();
        write_reg(sacl_pkg::CFG_REG_BLOCK, 8'd15);
        write_reg(sacl_pkg::CFG_REG_PAGE, 8'd31);
        send_idle_pct = 0;
        recv_stall_pct = 88;
        queue_random(350);
        drain();
        write_reg(sacl_pkg::CFG_REG_BLOCK, 8'd4);
        write_reg(sacl_pkg::CFG_REG_PAGE, 8'd12);
        send_idle_pct = 10;
        recv_stall_pct = 10;
        queue_random(400);
        drain();
        // long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 200;
        queue_random(400);
        drain();

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ set_assoc_cache_tag_lru_unit.f @@
+incdir+design
design/sacl_pkg.sv
design/sacl_ifs.sv
design/sacl_front.sv
design/sacl_queue.sv
design/sacl_back.sv
design/set_assoc_cache_tag_lru_unit.sv
sim/sacl_tb_pkg.sv
sim/set_assoc_cache_tag_lru_unit_tb.sv
